// File: hdl/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg: shared types and constants of the page replacement table
// Status codes, policy codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package prt_pkg;

   localparam int PageCountDefault  = 64;
   localparam int PoolDepthDefault  = 16;
   localparam int FrameCountDefault = 256;

   localparam logic [2:0] ST_HIT   = 3'd0;
   localparam logic [2:0] ST_FREE  = 3'd1;
   localparam logic [2:0] ST_EVICT = 3'd2;
   localparam logic [2:0] ST_PUSH  = 3'd3;
   localparam logic [2:0] ST_ERR   = 3'd4;

   localparam logic [1:0] POL_FIFO = 2'd0;
   localparam logic [1:0] POL_LRU  = 2'd1;
   localparam logic [1:0] POL_LFU  = 2'd2;

   localparam logic REG_POLICY = 1'b0;
   localparam logic REG_PAGES  = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK,
      S_SCAN,
      S_SCAN_LAST,
      S_KILL,
      S_FILL,
      S_OUT
   } state_type;

endpackage

// File: hdl/prt_csr.sv
// ----------------------------------------------------------------------------
// prt_csr: configuration registers
// Holds the replacement policy and the scan width behind an APB-style port.
// ----------------------------------------------------------------------------
module prt_csr
   import prt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [1:0]  policy,
   output logic [6:0]  pages_in_use
);

   logic [1:0] policy_ff;
   logic [6:0] pages_ff;
   logic       wr;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POL_FIFO;
         pages_ff  <= 7'd64;
      end else if (wr) begin
         if (paddr[2] == REG_POLICY) policy_ff <= pwdata[1:0];
         else                        pages_ff  <= pwdata[6:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[1:0] == 2'b00) begin
         if (paddr[2] == REG_POLICY) prdata = {30'd0, policy_ff};
         else                        prdata = {25'd0, pages_ff};
      end
   end

   assign policy = policy_ff;
   assign pages_in_use = pages_ff;

endmodule

// File: hdl/prt_table.sv
// ----------------------------------------------------------------------------
// prt_table: page table memory
// One synchronous memory of entries with a registered read and valid
// bits in flip-flops.
// ----------------------------------------------------------------------------
module prt_table
   import prt_pkg::*;
#(
   parameter int PAGE_COUNT = PageCountDefault,
   parameter int FRAME_W    = 8,
   localparam int AW = $clog2(PAGE_COUNT),
   localparam int EW = FRAME_W + 80
)(
   input  logic          clock,
   input  logic          reset,
   input  logic [AW-1:0] rd_addr,
   output logic [EW-1:0] rd_data,
   output logic          rd_valid,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [EW-1:0] wr_data,
   input  logic          wr_valid
);

   logic [EW-1:0]         mem [PAGE_COUNT];
   logic [PAGE_COUNT-1:0] valid_ff;
   logic [EW-1:0]         rd_data_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_addr];
         if (wr_en) valid_ff[wr_addr] <= wr_valid;
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

// File: hdl/page_replacement_table_unit.sv
// ----------------------------------------------------------------------------
// page_replacement_table_unit: page table with FIFO, LRU and LFU replacement
// Direct-indexed page table in a synchronous memory, a stack of free frames
// and a sequencer that scans the table for a victim when the pool is empty.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake        Payload
//  req_     in         req_valid/stall  mode, page index, free frame, time, last
//  rsp_     out        rsp_valid/stall  status, frame, evicted page, fault total
//  csr_     in/out     APB style        policy, pages_in_use
//
// A push, a hit or a fill from the pool passes through the table read, the
// decision with its write-back, and the load of the output register before
// the next word is accepted. A miss with an empty pool scans the table one
// entry a cycle through the single read port over the scan width (capped at
// PAGE_COUNT), then frees the victim, if any, and gives its frame to the page.
// Reset is synchronous and clears the valid bits, the pool count and the fault
// counter at once, with no sweep. The result waits in an output register; a
// new word is taken while it waits, but its own result is held back until the
// waiting word has been taken.
// ----------------------------------------------------------------------------
module page_replacement_table_unit
   import prt_pkg::*;
#(
   parameter int PAGE_COUNT  = PageCountDefault,
   parameter int POOL_DEPTH  = PoolDepthDefault,
   parameter int FRAME_COUNT = FrameCountDefault
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [5:0]  req_page_index,
   input  logic [7:0]  req_free_frame,
   input  logic [31:0] req_access_time,
   input  logic        req_last_reference,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_frame_number,
   output logic [5:0]  rsp_evicted_page,
   output logic [31:0] rsp_fault_total,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW  = $clog2(PAGE_COUNT);
   localparam int PW  = $clog2(POOL_DEPTH + 1);
   localparam int PIW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int EW  = 88;

   // Entry layout: frame, arrival, last use, uses.
   logic [1:0] policy;
   logic [6:0] pages_in_use;

   prt_csr u_csr (
      .clock, .reset,
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready), .policy, .pages_in_use
   );

   logic [AW-1:0] rd_addr;
   logic [EW-1:0] rd_data;
   logic          rd_valid;
   logic          wr_en, wr_valid;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   prt_table #(.PAGE_COUNT(PAGE_COUNT), .FRAME_W(8)) u_table (
      .clock, .reset, .rd_addr, .rd_data, .rd_valid,
      .wr_en, .wr_addr, .wr_data, .wr_valid
   );

   // Free frame stack: small, read at the top only.
   logic [7:0]    pool_ff [POOL_DEPTH];
   logic [PW-1:0] free_count_ff, free_count_in;
   logic          pool_push;
   logic [PIW-1:0] pool_top;

   state_type     state_ff, state_in;
   logic          mode_ff;
   logic [5:0]    page_ff;
   logic [7:0]    ffr_ff;
   logic [31:0]   time_ff;
   logic          last_ff;
   logic [31:0]   fault_ff, fault_in;

   logic [AW:0]   limit_ff, limit_in;
   logic [AW:0]   scan_ff, scan_in;
   logic          found_ff, found_in;
   logic [AW-1:0] best_ff, best_in;
   logic [7:0]    bframe_ff, bframe_in;
   logic [31:0]   bkey_ff, bkey_in, barr_ff, barr_in;
   logic [15:0]   buses_ff, buses_in;

   // The result of the word in progress, kept apart from the output register
   // so that a result still waiting there is never overwritten.
   logic [2:0]    res_st_ff, res_st_in;
   logic [7:0]    res_fr_ff, res_fr_in;
   logic [5:0]    res_ev_ff, res_ev_in;
   logic [31:0]   res_ft_ff, res_ft_in;

   logic          out_v_ff, out_v_in;
   logic [2:0]    out_st_ff, out_st_in;
   logic [7:0]    out_fr_ff, out_fr_in;
   logic [5:0]    out_ev_ff, out_ev_in;
   logic [31:0]   out_ft_ff, out_ft_in;

   logic        take;
   logic [7:0]  e_frame;
   logic [31:0] e_arr, e_lru;
   logic [15:0] e_uses;
   logic        better;
   logic [31:0] fault_inc;

   assign req_stall = (state_ff != S_IDLE);
   assign take = req_valid && !req_stall;
   assign {e_frame, e_arr, e_lru, e_uses} = rd_data;
   assign pool_top = PIW'(free_count_ff - PW'(1));
   assign fault_inc = (fault_ff == '1) ? fault_ff : fault_ff + 32'd1;

   always_comb begin
      case (policy)
         POL_LRU: better = e_lru < bkey_ff;
         POL_LFU: better = (e_uses != buses_ff) ? (e_uses < buses_ff) : (e_arr < barr_ff);
         default: better = e_arr < barr_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      rd_addr = take ? AW'(req_page_index) : scan_ff[AW-1:0];
      wr_en = 1'b0; wr_addr = AW'(page_ff); wr_data = '0; wr_valid = 1'b0;
      free_count_in = free_count_ff; pool_push = 1'b0;
      fault_in = fault_ff;
      limit_in = limit_ff; scan_in = scan_ff; found_in = found_ff; best_in = best_ff;
      bframe_in = bframe_ff; bkey_in = bkey_ff; barr_in = barr_ff; buses_in = buses_ff;
      res_st_in = res_st_ff; res_fr_in = res_fr_ff; res_ev_in = res_ev_ff;
      res_ft_in = res_ft_ff;
      out_v_in = out_v_ff && rsp_stall;
      out_st_in = out_st_ff; out_fr_in = out_fr_ff; out_ev_in = out_ev_ff;
      out_ft_in = out_ft_ff;
      case (state_ff)
         S_IDLE: if (take) state_in = S_LOOK;
         S_LOOK: begin
            res_st_in = ST_ERR; res_fr_in = '0; res_ev_in = '0; res_ft_in = fault_ff;
            state_in = S_OUT;
            if (mode_ff) begin
               if (free_count_ff < PW'(POOL_DEPTH) && 32'(ffr_ff) < 32'(FRAME_COUNT)) begin
                  pool_push = 1'b1;
                  free_count_in = free_count_ff + PW'(1);
                  res_st_in = ST_PUSH;
               end
            end else if (32'(page_ff) >= 32'(PAGE_COUNT)) begin
               // A page beyond the table is an error and changes nothing.
            end else if (rd_valid) begin
               wr_en = 1'b1; wr_valid = 1'b1;
               wr_data = {e_frame, e_arr, time_ff,
                          (e_uses == 16'hFFFF) ? e_uses : e_uses + 16'd1};
               res_st_in = ST_HIT; res_fr_in = e_frame;
            end else if (free_count_ff != '0) begin
               free_count_in = free_count_ff - PW'(1);
               wr_en = 1'b1; wr_valid = 1'b1;
               wr_data = {pool_ff[pool_top], time_ff, time_ff, 16'd1};
               res_st_in = ST_FREE; res_fr_in = pool_ff[pool_top];
               fault_in = fault_inc; res_ft_in = fault_inc;
            end else begin
               limit_in = (32'(pages_in_use) > 32'(PAGE_COUNT)) ?
                          (AW+1)'(PAGE_COUNT) : (AW+1)'(pages_in_use);
               scan_in = '0; found_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // The address scan_ff is presented; its data comes next cycle.
            if (scan_ff >= limit_ff) state_in = S_KILL;
            else begin
               scan_in = scan_ff + (AW+1)'(1);
               state_in = S_SCAN_LAST;
            end
         end
         S_SCAN_LAST: begin
            // rd_data is entry scan_ff-1; scan_ff is being read now.
            if (rd_valid && (!found_ff || better)) begin
               found_in = 1'b1; best_in = AW'(scan_ff - (AW+1)'(1));
               bframe_in = e_frame; bkey_in = e_lru; barr_in = e_arr; buses_in = e_uses;
            end
            if (scan_ff >= limit_ff) state_in = S_KILL;
            else scan_in = scan_ff + (AW+1)'(1);
         end
         S_KILL: begin
            state_in = S_OUT;
            if (found_ff) begin
               wr_en = 1'b1; wr_addr = best_ff; wr_valid = 1'b0; wr_data = '0;
               res_st_in = ST_EVICT; res_fr_in = bframe_ff;
               res_ev_in = 6'(best_ff);
               fault_in = fault_inc; res_ft_in = fault_inc;
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            // The new page takes over the victim's frame.
            wr_en = 1'b1; wr_valid = 1'b1;
            wr_data = {bframe_ff, time_ff, time_ff, 16'd1};
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!out_v_ff || !rsp_stall) begin
               out_v_in = 1'b1;
               out_st_in = res_st_ff; out_fr_in = res_fr_ff; out_ev_in = res_ev_ff;
               out_ft_in = res_ft_ff;
               if (last_ff) fault_in = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         free_count_ff <= '0;
         fault_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         free_count_ff <= free_count_in;
         fault_ff <= fault_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         mode_ff <= req_mode; page_ff <= req_page_index;
         ffr_ff <= req_free_frame; time_ff <= req_access_time;
         last_ff <= req_last_reference;
      end
      if (pool_push) pool_ff[PIW'(free_count_ff)] <= ffr_ff;
      limit_ff <= limit_in; scan_ff <= scan_in; found_ff <= found_in; best_ff <= best_in;
      bframe_ff <= bframe_in; bkey_ff <= bkey_in; barr_ff <= barr_in; buses_ff <= buses_in;
      res_st_ff <= res_st_in; res_fr_ff <= res_fr_in; res_ev_ff <= res_ev_in;
      res_ft_ff <= res_ft_in;
      out_st_ff <= out_st_in; out_fr_ff <= out_fr_in; out_ev_ff <= out_ev_in;
      out_ft_ff <= out_ft_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_status = out_st_ff;
   assign rsp_frame_number = out_fr_ff;
   assign rsp_evicted_page = out_ev_ff;
   assign rsp_fault_total = out_ft_ff;

   // The pool never holds more frames than it has slots.
   assert property (@(posedge clock) disable iff (reset) free_count_ff <= PW'(POOL_DEPTH))
      else $error("pool count overflow");
   // A word is only taken while the sequencer is idle.
   assert property (@(posedge clock) disable iff (reset) take |=> state_ff == S_LOOK)
      else $error("item taken outside idle");
   // The scan never runs past the table.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN_LAST |-> scan_ff <= (AW+1)'(PAGE_COUNT))
      else $error("scan past table");
   // A stalled result word holds still.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_frame_number) && $stable(rsp_evicted_page) && $stable(rsp_fault_total))
      else $error("stalled result changed");

endmodule
